### rtl/mcpt_pkg.sv
// Shared constants and types for the MIDI clock position and tempo core.
// No dependencies.
`default_nettype none
package mcpt_pkg;

    localparam int unsigned CLOCKS_PER_SIXTEENTH = 6;
    localparam int unsigned SIXTEENTHS_PER_BEAT  = 4;
    localparam int unsigned BEATS_IN_BAR_DEFAULT = 4;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned BAR_W   = 26;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned TEMPO_W = 15;
    localparam int unsigned NUM_W   = 25;
    localparam int unsigned OUT_W   = 80;

    localparam logic [NUM_W-1:0]   TEMPO_NUMERATOR    = NUM_W'(25000000);
    localparam logic [TEMPO_W-1:0] TEMPO_MAX          = '1;
    localparam logic [TIME_W-1:0]  MIN_INTERVAL_RESET = TIME_W'(1000);

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] total;
        logic [BAR_W-1:0]  bar;
        logic [IDX_W-1:0]  beat;
        logic [IDX_W-1:0]  sixteenth;
        logic              boundary;
    } pos_t;

endpackage
`default_nettype wire

### rtl/midi_clock_position_tempo_core.sv
// A start or a noise tick goes from ST_IDLE to ST_EMIT and then into the output
// register; a tick that updates the tempo first waits in ST_DIV for the bit-serial
// divider (25 quotient bits). Only one item is in flight at a time: s_tready is high
// only in ST_IDLE, and ST_EMIT waits for m_tready before the result is registered.
// Reset (aresetn low, synchronous) clears count, position, tempo, last timestamp,
// and sets min_interval_us to 1000. Depends on mcpt_pkg, mcpt_position, mcpt_divider.
`default_nettype none
module midi_clock_position_tempo_core
    import mcpt_pkg::*;
#(
    parameter int unsigned BEATS_IN_BAR = BEATS_IN_BAR_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [TIME_W-1:0] s_tdata,   // [31:0] timestamp_us
    input  wire logic              s_tuser,   // [0] operation
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,   // [31:0] clock_total, [57:32] bar_index,
                                              // [59:58] beat_index, [61:60] sixteenth_index,
                                              // [76:62] tempo_tenths, [77] beat_boundary
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [TIME_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic [TIME_W-1:0]   min_reg;
    logic [TIME_W-1:0]   last_reg;
    logic [TEMPO_W-1:0]  tempo_reg;
    logic                start_res_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    logic                accept;
    logic                is_start;
    logic [TIME_W-1:0]   interval;
    logic                measure;
    logic                div_done;
    logic [NUM_W-1:0]    div_q;
    logic [TEMPO_W-1:0]  tempo_next;
    logic                out_free;
    pos_t                pos;
    logic                bound_out;

    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign is_start  = s_tuser == OP_START;
    assign interval  = s_tdata - last_reg;
    assign measure   = accept && !is_start && (interval > min_reg);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign bound_out = pos.boundary && !start_res_reg;

    always_comb begin
        if (div_q > NUM_W'(TEMPO_MAX)) begin
            tempo_next = TEMPO_MAX;
        end else begin
            tempo_next = div_q[TEMPO_W-1:0];
        end
    end

    mcpt_position #(
        .BEATS_IN_BAR(BEATS_IN_BAR)
    ) u_position (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (accept && !is_start),
        .clear   (accept && is_start),
        .pos     (pos)
    );

    mcpt_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (measure),
        .divisor  (interval),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            min_reg       <= MIN_INTERVAL_RESET;
            last_reg      <= '0;
            tempo_reg     <= '0;
            start_res_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                min_reg <= cfg_data;
            end
            if (state_reg == ST_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {2'b00, bound_out, tempo_reg, pos.sixteenth, pos.beat,
                                 pos.bar, pos.total};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        start_res_reg <= is_start;
                        if (is_start) begin
                            tempo_reg <= '0;
                            state_reg <= ST_EMIT;
                        end else begin
                            last_reg  <= s_tdata;
                            state_reg <= measure ? ST_DIV : ST_EMIT;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        tempo_reg <= tempo_next;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

### rtl/mcpt_divider.sv
// Bit-serial restoring divider: tempo numerator over a 32-bit interval,
// one quotient bit per cycle. Depends on mcpt_pkg.
`default_nettype none
module mcpt_divider
    import mcpt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [TIME_W-1:0] divisor,
    output logic                   done,
    output logic [NUM_W-1:0]       quotient
);

    localparam int unsigned CNT_W = $clog2(NUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] div_reg;

    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   diff;
    logic              ge;
    logic [TIME_W-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        diff     = trial - {1'b0, div_reg};
        ge       = trial >= {1'b0, div_reg};
        rem_next = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(NUM_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= TEMPO_NUMERATOR;
            quo_reg <= '0;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

### rtl/mcpt_position.sv
// Song position counters: total clocks, bar, beat and sixteenth, advanced
// one tick at a time and cleared on start. Depends on mcpt_pkg.
`default_nettype none
module mcpt_position
    import mcpt_pkg::*;
#(
    parameter int unsigned BEATS_IN_BAR = BEATS_IN_BAR_DEFAULT
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic tick,
    input  wire logic clear,
    output pos_t      pos
);

    localparam int unsigned BEAT_W = (BEATS_IN_BAR > 1) ? $clog2(BEATS_IN_BAR) : 1;
    localparam int unsigned SUB_W  = $clog2(CLOCKS_PER_SIXTEENTH);

    logic [TIME_W-1:0] total_reg;
    logic [BAR_W-1:0]  bar_reg;
    logic [BEAT_W-1:0] beat_reg;
    logic [IDX_W-1:0]  six_reg;
    logic [SUB_W-1:0]  sub_reg;

    logic              sub_wrap;
    logic              six_wrap;
    logic              beat_wrap;
    logic [BEAT_W+1:0] beat_ext;

    always_comb begin
        sub_wrap  = sub_reg == SUB_W'(CLOCKS_PER_SIXTEENTH - 1);
        six_wrap  = six_reg == IDX_W'(SIXTEENTHS_PER_BEAT - 1);
        beat_wrap = beat_reg == BEAT_W'(BEATS_IN_BAR - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            total_reg <= '0;
            bar_reg   <= '0;
            beat_reg  <= '0;
            six_reg   <= '0;
            sub_reg   <= '0;
        end else if (tick) begin
            total_reg <= total_reg + TIME_W'(1);
            if (&total_reg) begin
                bar_reg  <= '0;
                beat_reg <= '0;
                six_reg  <= '0;
                sub_reg  <= '0;
            end else if (sub_wrap) begin
                sub_reg <= '0;
                if (six_wrap) begin
                    six_reg <= '0;
                    if (beat_wrap) begin
                        beat_reg <= '0;
                        bar_reg  <= bar_reg + BAR_W'(1);
                    end else begin
                        beat_reg <= beat_reg + BEAT_W'(1);
                    end
                end else begin
                    six_reg <= six_reg + IDX_W'(1);
                end
            end else begin
                sub_reg <= sub_reg + SUB_W'(1);
            end
        end
    end

    assign beat_ext = {2'b00, beat_reg};

    always_comb begin
        pos.total     = total_reg;
        pos.bar       = bar_reg;
        pos.beat      = beat_ext[IDX_W-1:0];
        pos.sixteenth = six_reg;
        pos.boundary  = (sub_reg == '0) && (six_reg == '0);
    end

endmodule
`default_nettype wire
